### rtl/ring_log_offset_locator_defines.svh
// Assertion macros for the ring log offset locator.
// Included by the top level; no other dependencies.
`ifndef RING_LOG_OFFSET_LOCATOR_DEFINES_SVH
`define RING_LOG_OFFSET_LOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define RLOL_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define RLOL_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define RLOL_ASSERT(lbl, clk, rstn, prop, msg)
`define RLOL_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

### rtl/rlol_pkg.sv
// Shared types and constants for the ring log offset locator.
// No dependencies.
`default_nettype none
package rlol_pkg;
    localparam int DEPTH_DEF       = 16;
    localparam int LENGTH_BITS_DEF = 16;
    localparam int HANDLE_BITS     = 32;
    localparam int IN_LEN_BITS     = 16;
    localparam int OFFSET_BITS     = 20;
    localparam int SLOT_OUT_BITS   = 4;
    localparam int OFS_OUT_BITS    = 16;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_FIND = 1'b1;

    typedef struct packed {
        logic                   kind;
        logic [HANDLE_BITS-1:0] record_handle;
        logic [IN_LEN_BITS-1:0] record_length;
        logic [OFFSET_BITS-1:0] byte_offset;
    } cmd_t;

    typedef struct packed {
        logic                     found;
        logic [SLOT_OUT_BITS-1:0] slot;
        logic [HANDLE_BITS-1:0]   found_handle;
        logic [OFS_OUT_BITS-1:0]  offset_in_record;
        logic                     overwrote_oldest;
    } result_t;

    typedef struct packed {
        logic load;
        logic shift;
    } chain_ctl_t;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;
endpackage
`default_nettype wire

### rtl/rlol_cell.sv
// One record cell of the chain: handle, length and ring slot tag.
// Depends on rlol_pkg.
`default_nettype none
module rlol_cell #(
    parameter int LENGTH_BITS = rlol_pkg::LENGTH_BITS_DEF,
    parameter int SLOT_BITS   = $clog2(rlol_pkg::DEPTH_DEF)
) (
    input  wire                              clk,
    input  wire rlol_pkg::chain_ctl_t        ctl,
    input  wire                              sel,
    input  wire [rlol_pkg::HANDLE_BITS-1:0]  new_handle,
    input  wire [LENGTH_BITS-1:0]            new_len,
    input  wire [SLOT_BITS-1:0]              new_tag,
    input  wire [rlol_pkg::HANDLE_BITS-1:0]  nbr_handle,
    input  wire [LENGTH_BITS-1:0]            nbr_len,
    input  wire [SLOT_BITS-1:0]              nbr_tag,
    output logic [rlol_pkg::HANDLE_BITS-1:0] handle,
    output logic [LENGTH_BITS-1:0]           len,
    output logic [SLOT_BITS-1:0]             tag
);
    logic [rlol_pkg::HANDLE_BITS-1:0] handle_reg, handle_next;
    logic [LENGTH_BITS-1:0]           len_reg, len_next;
    logic [SLOT_BITS-1:0]             tag_reg, tag_next;

    always_comb
    begin
        handle_next = handle_reg;
        len_next    = len_reg;
        tag_next    = tag_reg;
        if (ctl.load && sel)
        begin
            handle_next = new_handle;
            len_next    = new_len;
            tag_next    = new_tag;
        end
        else if (ctl.shift)
        begin
            handle_next = nbr_handle;
            len_next    = nbr_len;
            tag_next    = nbr_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        handle_reg <= handle_next;
        len_reg    <= len_next;
        tag_reg    <= tag_next;
    end

    assign handle = handle_reg;
    assign len    = len_reg;
    assign tag    = tag_reg;
endmodule
`default_nettype wire

### rtl/rlol_ctrl.sv
// Command sequencer: record count, write slot, walk over the chain head.
// Depends on rlol_pkg.
`default_nettype none
module rlol_ctrl #(
    parameter int DEPTH       = rlol_pkg::DEPTH_DEF,
    parameter int LENGTH_BITS = rlol_pkg::LENGTH_BITS_DEF,
    parameter int SLOT_BITS   = $clog2(DEPTH)
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              start,
    input  wire rlol_pkg::cmd_t              cmd,
    input  wire [rlol_pkg::HANDLE_BITS-1:0]  head_handle,
    input  wire [LENGTH_BITS-1:0]            head_len,
    input  wire [SLOT_BITS-1:0]              head_tag,
    output rlol_pkg::chain_ctl_t             ctl,
    output logic [SLOT_BITS-1:0]             load_pos,
    output logic [LENGTH_BITS-1:0]           new_len,
    output logic [SLOT_BITS-1:0]             new_tag,
    output logic                             busy,
    output logic                             done,
    output rlol_pkg::result_t                result
);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CW    = (LENGTH_BITS > rlol_pkg::OFFSET_BITS) ?
                           LENGTH_BITS : rlol_pkg::OFFSET_BITS;

    rlol_pkg::state_t  state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SLOT_BITS-1:0] wslot_reg, wslot_next;
    logic [SLOT_BITS-1:0] walk_reg, walk_next;
    logic              matched_reg, matched_next;
    logic              done_reg, done_next;
    logic [rlol_pkg::OFFSET_BITS-1:0] rem_reg, rem_next;
    rlol_pkg::result_t res_reg, res_next;

    logic                  full;
    logic [CW-1:0]         rem_x, len_x, diff_x;
    logic [SLOT_BITS+rlol_pkg::SLOT_OUT_BITS-1:0] wslot_ext, tag_ext;
    logic [LENGTH_BITS+rlol_pkg::IN_LEN_BITS-1:0] len_ext;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign rem_x     = CW'(rem_reg);
    assign len_x     = CW'(head_len);
    assign diff_x    = rem_x - len_x;
    assign wslot_ext = {{rlol_pkg::SLOT_OUT_BITS{1'b0}}, wslot_reg};
    assign tag_ext   = {{rlol_pkg::SLOT_OUT_BITS{1'b0}}, head_tag};
    assign len_ext   = {{LENGTH_BITS{1'b0}}, cmd.record_length};
    assign new_len   = len_ext[LENGTH_BITS-1:0];
    assign new_tag   = wslot_reg;
    assign load_pos  = full ? SLOT_BITS'(DEPTH - 1) : count_reg[SLOT_BITS-1:0];

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        wslot_next   = wslot_reg;
        walk_next    = walk_reg;
        matched_next = matched_reg;
        done_next    = 1'b0;
        rem_next     = rem_reg;
        res_next     = res_reg;
        ctl          = '0;
        case (state_reg)
            rlol_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    res_next = '0;
                    if (cmd.kind == rlol_pkg::KIND_ADD)
                    begin
                        ctl.load  = 1'b1;
                        ctl.shift = full;
                        if (!full)
                            count_next = count_reg + 1'b1;
                        wslot_next = (wslot_reg == SLOT_BITS'(DEPTH - 1)) ?
                                     '0 : wslot_reg + 1'b1;
                        res_next.slot             = wslot_ext[rlol_pkg::SLOT_OUT_BITS-1:0];
                        res_next.overwrote_oldest = full;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        rem_next     = cmd.byte_offset;
                        walk_next    = '0;
                        matched_next = 1'b0;
                        state_next   = rlol_pkg::ST_WALK;
                    end
                end
            end
            rlol_pkg::ST_WALK:
            begin
                ctl.shift = 1'b1;
                if (!matched_reg && (CNT_W'(walk_reg) < count_reg))
                begin
                    if (rem_x < len_x)
                    begin
                        matched_next              = 1'b1;
                        res_next.found            = 1'b1;
                        res_next.slot             = tag_ext[rlol_pkg::SLOT_OUT_BITS-1:0];
                        res_next.found_handle     = head_handle;
                        res_next.offset_in_record = rem_reg[rlol_pkg::OFS_OUT_BITS-1:0];
                    end
                    else
                        rem_next = diff_x[rlol_pkg::OFFSET_BITS-1:0];
                end
                walk_next = walk_reg + 1'b1;
                if (walk_reg == SLOT_BITS'(DEPTH - 1))
                begin
                    state_next = rlol_pkg::ST_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
                state_next = rlol_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rlol_pkg::ST_IDLE;
            count_reg   <= '0;
            wslot_reg   <= '0;
            walk_reg    <= '0;
            matched_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            wslot_reg   <= wslot_next;
            walk_reg    <= walk_next;
            matched_reg <= matched_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
    end

    assign busy   = (state_reg == rlol_pkg::ST_WALK);
    assign done   = done_reg;
    assign result = res_reg;
endmodule
`default_nettype wire

### rtl/ring_log_offset_locator.sv
// Add: result in the cycle after start; another item may start the cycle after.
// Find: busy while the record chain rotates once past the head cell; result
// strobes on done in the cycle after the last step.
// Records are kept oldest first along the chain; the rotation restores them.
// rst_n clears count, slots and sequencer at once; record contents are not reset.
// The result is held until the next command starts.
`default_nettype none
`include "ring_log_offset_locator_defines.svh"
module ring_log_offset_locator #(
    parameter int DEPTH       = rlol_pkg::DEPTH_DEF,
    parameter int LENGTH_BITS = rlol_pkg::LENGTH_BITS_DEF
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               start,
    output logic              busy,
    input  wire rlol_pkg::cmd_t cmd,
    output logic              done,
    output rlol_pkg::result_t result
);
    localparam int SLOT_BITS = $clog2(DEPTH);

    rlol_pkg::chain_ctl_t           ctl;
    logic [SLOT_BITS-1:0]           load_pos;
    logic [LENGTH_BITS-1:0]         new_len;
    logic [SLOT_BITS-1:0]           new_tag;
    logic [rlol_pkg::HANDLE_BITS-1:0] c_handle [DEPTH];
    logic [LENGTH_BITS-1:0]           c_len    [DEPTH];
    logic [SLOT_BITS-1:0]             c_tag    [DEPTH];
    logic                             take_add;
    logic                             take_find;
    logic                             miss_clear;

    rlol_ctrl #(
        .DEPTH       (DEPTH),
        .LENGTH_BITS (LENGTH_BITS),
        .SLOT_BITS   (SLOT_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .cmd         (cmd),
        .head_handle (c_handle[0]),
        .head_len    (c_len[0]),
        .head_tag    (c_tag[0]),
        .ctl         (ctl),
        .load_pos    (load_pos),
        .new_len     (new_len),
        .new_tag     (new_tag),
        .busy        (busy),
        .done        (done),
        .result      (result)
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        rlol_cell #(
            .LENGTH_BITS (LENGTH_BITS),
            .SLOT_BITS   (SLOT_BITS)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .sel        (load_pos == SLOT_BITS'(i)),
            .new_handle (cmd.record_handle),
            .new_len    (new_len),
            .new_tag    (new_tag),
            .nbr_handle (c_handle[(i + 1) % DEPTH]),
            .nbr_len    (c_len[(i + 1) % DEPTH]),
            .nbr_tag    (c_tag[(i + 1) % DEPTH]),
            .handle     (c_handle[i]),
            .len        (c_len[i]),
            .tag        (c_tag[i])
        );
    end

    assign take_add   = start && !busy && (cmd.kind == rlol_pkg::KIND_ADD);
    assign take_find  = start && !busy && (cmd.kind == rlol_pkg::KIND_FIND);
    assign miss_clear = (result.found_handle == '0) && (result.offset_in_record == '0);

    `RLOL_NEVER(a_done_busy, clk, rst_n, done && busy, "result beat while walking")
    `RLOL_ASSERT(a_find_walk, clk, rst_n, take_find |=> busy, "find did not start walk")
    `RLOL_ASSERT(a_add_done, clk, rst_n, take_add |=> (done && !result.found), "add result missing")
    `RLOL_ASSERT(a_miss_zero, clk, rst_n, (done && !result.found) |-> miss_clear, "miss not cleared")
endmodule
`default_nettype wire
